// ===== src/bsd_pkg.sv =====
`timescale 1ns / 1ps
package bsd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [3:0] event_res;
		logic [7:0] out_byte;
		logic       printable;
		logic [1:0] error_code;
		logic       last;
	} out_t;

	typedef enum logic [3:0] {
		EV_DICT_BEGIN = 4'd0,
		EV_DICT_END   = 4'd1,
		EV_LIST_BEGIN = 4'd2,
		EV_LIST_END   = 4'd3,
		EV_INT_CHAR   = 4'd4,
		EV_INT_END    = 4'd5,
		EV_STR_BYTE   = 4'd6,
		EV_STR_END    = 4'd7,
		EV_ERROR      = 4'd8,
		EV_DONE       = 4'd9
	} event_t;

	typedef enum logic [1:0] {
		ERR_TOKEN = 2'd0,
		ERR_COLON = 2'd1,
		ERR_STACK = 2'd2,
		ERR_TRUNC = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		MODE_TOKEN,
		MODE_INT,
		MODE_LEN,
		MODE_STR,
		MODE_HALT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STR_END,
		ST_CLOSE,
		ST_UNWIND_CHK,
		ST_UNWIND_EMIT
	} state_t;

	localparam logic [7:0] CH_DICT  = 8'h64;
	localparam logic [7:0] CH_INT   = 8'h69;
	localparam logic [7:0] CH_LIST  = 8'h6c;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3a;

	typedef struct packed {
		logic   load;
		logic   push;
		logic   push_kind;
		logic   pop;
		logic   len_load;
		logic   len_mac;
		logic   len_dec;
		logic   emit;
		event_t ev;
		err_t   err;
		logic   last;
	} cmd_t;

	typedef struct packed {
		logic is_dict;
		logic is_list;
		logic is_int;
		logic is_end;
		logic is_colon;
		logic is_digit;
		logic eoi;
		logic depth_zero;
		logic depth_full;
		logic len_zero;
		logic len_one;
		logic len_ovf;
		logic top_kind;
		logic out_free;
	} status_t;

endpackage

// ===== src/bsd_ctrl.sv =====
`timescale 1ns / 1ps
module bsd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  bsd_pkg::status_t st,
	output logic             idle,
	output bsd_pkg::cmd_t    cmd
);

	bsd_pkg::state_t state_q, state_d;
	bsd_pkg::mode_t  mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsd_pkg::ST_IDLE;
			mode_q  <= bsd_pkg::MODE_TOKEN;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	assign idle = (state_q == bsd_pkg::ST_IDLE);

	always_comb begin
		state_d       = state_q;
		mode_d        = mode_q;
		cmd           = '0;
		cmd.ev        = bsd_pkg::EV_ERROR;
		cmd.err       = bsd_pkg::ERR_TOKEN;
		case (state_q)
			bsd_pkg::ST_IDLE: begin
				if (item_valid && mode_q != bsd_pkg::MODE_HALT) begin
					cmd.load = 1'b1;
					state_d  = bsd_pkg::ST_DECODE;
				end
			end
			bsd_pkg::ST_DECODE: begin
				if (st.out_free) begin
					state_d = bsd_pkg::ST_IDLE;
					if (st.eoi) begin
						case (mode_q)
							bsd_pkg::MODE_LEN, bsd_pkg::MODE_STR: begin
								cmd.emit = 1'b1;
								cmd.err  = bsd_pkg::ERR_TRUNC;
								cmd.last = 1'b1;
								mode_d   = bsd_pkg::MODE_HALT;
							end
							bsd_pkg::MODE_INT: begin
								cmd.emit = 1'b1;
								cmd.ev   = bsd_pkg::EV_INT_END;
								state_d  = bsd_pkg::ST_UNWIND_CHK;
							end
							default: state_d = bsd_pkg::ST_UNWIND_CHK;
						endcase
					end else begin
						case (mode_q)
							bsd_pkg::MODE_TOKEN: begin
								if (st.is_dict || st.is_list) begin
									cmd.emit = 1'b1;
									cmd.last = 1'b1;
									if (st.depth_full) begin
										cmd.err = bsd_pkg::ERR_STACK;
										mode_d  = bsd_pkg::MODE_HALT;
									end else begin
										cmd.push      = 1'b1;
										cmd.push_kind = st.is_dict;
										cmd.ev        = st.is_dict ? bsd_pkg::EV_DICT_BEGIN
										                           : bsd_pkg::EV_LIST_BEGIN;
									end
								end else if (st.is_int) begin
									mode_d = bsd_pkg::MODE_INT;
								end else if (st.is_end && !st.depth_zero) begin
									cmd.pop = 1'b1;
									state_d = bsd_pkg::ST_CLOSE;
								end else if (st.is_digit) begin
									cmd.len_load = 1'b1;
									mode_d       = bsd_pkg::MODE_LEN;
								end else begin
									cmd.emit = 1'b1;
									cmd.last = 1'b1;
									mode_d   = bsd_pkg::MODE_HALT;
								end
							end
							bsd_pkg::MODE_INT: begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								if (st.is_end) begin
									cmd.ev = bsd_pkg::EV_INT_END;
									mode_d = bsd_pkg::MODE_TOKEN;
								end else begin
									cmd.ev = bsd_pkg::EV_INT_CHAR;
								end
							end
							bsd_pkg::MODE_LEN: begin
								if (st.is_digit && !st.len_ovf) begin
									cmd.len_mac = 1'b1;
								end else if (st.is_colon) begin
									if (st.len_zero) begin
										cmd.emit = 1'b1;
										cmd.ev   = bsd_pkg::EV_STR_END;
										cmd.last = 1'b1;
										mode_d   = bsd_pkg::MODE_TOKEN;
									end else begin
										mode_d = bsd_pkg::MODE_STR;
									end
								end else begin
									cmd.emit = 1'b1;
									cmd.err  = bsd_pkg::ERR_COLON;
									cmd.last = 1'b1;
									mode_d   = bsd_pkg::MODE_HALT;
								end
							end
							bsd_pkg::MODE_STR: begin
								cmd.emit    = 1'b1;
								cmd.ev      = bsd_pkg::EV_STR_BYTE;
								cmd.len_dec = 1'b1;
								if (st.len_one) begin
									state_d = bsd_pkg::ST_STR_END;
								end else begin
									cmd.last = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			bsd_pkg::ST_STR_END: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.ev   = bsd_pkg::EV_STR_END;
					cmd.last = 1'b1;
					mode_d   = bsd_pkg::MODE_TOKEN;
					state_d  = bsd_pkg::ST_IDLE;
				end
			end
			bsd_pkg::ST_CLOSE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.ev   = st.top_kind ? bsd_pkg::EV_DICT_END : bsd_pkg::EV_LIST_END;
					cmd.last = 1'b1;
					state_d  = bsd_pkg::ST_IDLE;
				end
			end
			bsd_pkg::ST_UNWIND_CHK: begin
				if (!st.depth_zero) begin
					cmd.pop = 1'b1;
					state_d = bsd_pkg::ST_UNWIND_EMIT;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.ev   = bsd_pkg::EV_DONE;
					cmd.last = 1'b1;
					mode_d   = bsd_pkg::MODE_HALT;
					state_d  = bsd_pkg::ST_IDLE;
				end
			end
			bsd_pkg::ST_UNWIND_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.ev   = st.top_kind ? bsd_pkg::EV_DICT_END : bsd_pkg::EV_LIST_END;
					state_d  = bsd_pkg::ST_UNWIND_CHK;
				end
			end
			default: state_d = bsd_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== src/bsd_datapath.sv =====
`timescale 1ns / 1ps
module bsd_datapath #(
	parameter int STACK_DEPTH = 16,
	parameter int LEN_BITS    = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bsd_pkg::in_t     item,
	input  bsd_pkg::cmd_t    cmd,
	input  logic             res_stall,
	output bsd_pkg::status_t st,
	output logic             res_valid,
	output bsd_pkg::out_t    res
);

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [7:0]          byte_q;
	logic                eoi_q;
	logic [LEN_BITS-1:0] len_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                kind_mem [STACK_DEPTH];
	logic                top_kind_q;
	logic                res_valid_q;
	bsd_pkg::out_t       res_q;

	logic [LEN_BITS+3:0] len_ext;
	logic [LEN_BITS+3:0] len_mac;
	logic [DEPTH_W-1:0]  depth_dec;
	logic [3:0]          digit;
	logic                carries_byte;

	assign digit     = byte_q[3:0];
	assign len_ext   = {4'b0000, len_q};
	assign len_mac   = (len_ext << 3) + (len_ext << 1) + {{LEN_BITS{1'b0}}, digit};
	assign depth_dec = depth_q - DEPTH_W'(1);

	always_comb begin
		st            = '0;
		st.is_dict    = (byte_q == bsd_pkg::CH_DICT);
		st.is_list    = (byte_q == bsd_pkg::CH_LIST);
		st.is_int     = (byte_q == bsd_pkg::CH_INT);
		st.is_end     = (byte_q == bsd_pkg::CH_END);
		st.is_colon   = (byte_q == bsd_pkg::CH_COLON);
		st.is_digit   = (byte_q >= 8'h30) && (byte_q <= 8'h39);
		st.eoi        = eoi_q;
		st.depth_zero = (depth_q == '0);
		st.depth_full = (depth_q == DEPTH_W'(STACK_DEPTH));
		st.len_zero   = (len_q == '0);
		st.len_one    = (len_q == LEN_BITS'(1));
		st.len_ovf    = |len_mac[LEN_BITS+3:LEN_BITS];
		st.top_kind   = top_kind_q;
		st.out_free   = !res_valid_q || !res_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= item.in_byte;
			eoi_q  <= item.end_of_input;
		end
		if (cmd.len_load) begin
			len_q <= LEN_BITS'(digit);
		end else if (cmd.len_mac) begin
			len_q <= len_mac[LEN_BITS-1:0];
		end else if (cmd.len_dec) begin
			len_q <= len_q - LEN_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kind_mem[depth_q[IDX_W-1:0]] <= cmd.push_kind;
		end
		if (cmd.pop) begin
			top_kind_q <= kind_mem[depth_dec[IDX_W-1:0]];
		end
	end

	assign carries_byte = (cmd.ev == bsd_pkg::EV_INT_CHAR) || (cmd.ev == bsd_pkg::EV_STR_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.event_res  <= cmd.ev;
			res_q.out_byte   <= carries_byte ? byte_q : 8'h00;
			res_q.printable  <= (cmd.ev == bsd_pkg::EV_STR_BYTE) &&
			                    (byte_q >= 8'h20) && (byte_q <= 8'h7e);
			res_q.error_code <= (cmd.ev == bsd_pkg::EV_ERROR) ? cmd.err : bsd_pkg::ERR_TOKEN;
			res_q.last       <= cmd.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== src/bencode_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// Bencode stream decoder: one byte beat in, a stream of event beats out, the
// final event of each input beat flagged by last. An ordinary byte is
// captured, then decoded in the controller. The string end event after the
// final byte of a string is sent from a further state, and so is the end
// event of a container close, which reads the kind stack through its
// registered read port first. End of input closes every open container,
// each close again reading the kind stack first, then sends a done event;
// it sends a truncation error instead when it arrives while a string
// length or string body is being read. Stalls on the result side can hold
// any of these steps. The first error or done event halts the decoder:
// further input beats are accepted and dropped until reset.
module bencode_stream_decoder_core #(
	parameter int STACK_DEPTH = 16,
	parameter int LEN_BITS    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  bsd_pkg::in_t  item,
	output logic          res_valid,
	input  logic          res_stall,
	output bsd_pkg::out_t res
);

	bsd_pkg::cmd_t    cmd;
	bsd_pkg::status_t st;
	logic             idle;

	bsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.st         (st),
		.idle       (idle),
		.cmd        (cmd)
	);

	bsd_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.LEN_BITS    (LEN_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.res_stall (res_stall),
		.st        (st),
		.res_valid (res_valid),
		.res       (res)
	);

	assign item_stall = !idle;

endmodule

// ===== src/bsd_checker.sv =====
`timescale 1ns / 1ps
module bsd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_stall,
	input bsd_pkg::out_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res != bsd_pkg::EV_STR_BYTE |-> !res.printable)
		else $error("printable set outside string byte");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.event_res == bsd_pkg::EV_ERROR ||
		              res.event_res == bsd_pkg::EV_DONE) |-> res.last)
		else $error("terminal event not last of its beat");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res != bsd_pkg::EV_STR_BYTE &&
		res.event_res != bsd_pkg::EV_INT_CHAR |-> res.out_byte == 8'h00)
		else $error("byte field set on event without data");

endmodule

bind bencode_stream_decoder_core bsd_checker u_bsd_checker (.*);

// ===== tb/sv/bencode_checker.sv =====
`timescale 1ns / 1ps
module bencode_checker #(
	parameter int STACK_DEPTH = 16,
	parameter int LEN_BITS    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_stall,
	input  bsd_pkg::in_t  item,
	input  logic          res_valid,
	input  logic          res_stall,
	input  bsd_pkg::out_t res,
	output int            fail_count,
	output int            pending
);
	import bsd_pkg::*;

	localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;

	mode_t           dec_mode;
	logic            kinds [STACK_DEPTH];
	int unsigned     depth;
	longint unsigned len_left;
	out_t            events_due [$];
	int              mismatches = 0;
	int              beats_seen = 0;

	task automatic report(input string msg);
		$display("checker: result beat %0d: %s", beats_seen, msg);
		mismatches++;
	endtask

	task automatic add_event(input event_t ev, input logic [7:0] b, input logic pr,
			input err_t code);
		out_t r;
		r = '{event_res: ev, out_byte: b, printable: pr, error_code: code, last: 1'b0};
		events_due.push_back(r);
	endtask

	task automatic stop_on_error(input err_t code);
		dec_mode = MODE_HALT;
		add_event(EV_ERROR, 8'h00, 1'b0, code);
	endtask

	task automatic begin_container(input logic is_dict);
		if (depth >= STACK_DEPTH) begin
			stop_on_error(ERR_STACK);
		end else begin
			kinds[depth] = is_dict;
			depth++;
			add_event(is_dict ? EV_DICT_BEGIN : EV_LIST_BEGIN, 8'h00, 1'b0, ERR_TOKEN);
		end
	endtask

	task automatic end_container();
		depth--;
		add_event(kinds[depth] ? EV_DICT_END : EV_LIST_END, 8'h00, 1'b0, ERR_TOKEN);
	endtask

	task automatic unwind_stream();
		if (dec_mode == MODE_LEN || dec_mode == MODE_STR) begin
			stop_on_error(ERR_TRUNC);
		end else begin
			if (dec_mode == MODE_INT)
				add_event(EV_INT_END, 8'h00, 1'b0, ERR_TOKEN);
			while (depth > 0)
				end_container();
			dec_mode = MODE_HALT;
			add_event(EV_DONE, 8'h00, 1'b0, ERR_TOKEN);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic is_digit;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		case (dec_mode)
			MODE_TOKEN: begin
				if (b == CH_DICT) begin
					begin_container(1'b1);
				end else if (b == CH_LIST) begin
					begin_container(1'b0);
				end else if (b == CH_INT) begin
					dec_mode = MODE_INT;
				end else if (b == CH_END) begin
					if (depth == 0)
						stop_on_error(ERR_TOKEN);
					else
						end_container();
				end else if (is_digit) begin
					len_left = longint'(b - CH_ZERO);
					dec_mode = MODE_LEN;
				end else begin
					stop_on_error(ERR_TOKEN);
				end
			end
			MODE_INT: begin
				if (b == CH_END) begin
					dec_mode = MODE_TOKEN;
					add_event(EV_INT_END, 8'h00, 1'b0, ERR_TOKEN);
				end else begin
					add_event(EV_INT_CHAR, b, 1'b0, ERR_TOKEN);
				end
			end
			MODE_LEN: begin
				if (is_digit) begin
					len_left = len_left * 10 + longint'(b - CH_ZERO);
					if (len_left > LEN_MAX)
						stop_on_error(ERR_COLON);
				end else if (b != CH_COLON) begin
					stop_on_error(ERR_COLON);
				end else if (len_left == 0) begin
					dec_mode = MODE_TOKEN;
					add_event(EV_STR_END, 8'h00, 1'b0, ERR_TOKEN);
				end else begin
					dec_mode = MODE_STR;
				end
			end
			MODE_STR: begin
				add_event(EV_STR_BYTE, b, (b >= PRINT_LO) && (b <= PRINT_HI), ERR_TOKEN);
				if (len_left > 0)
					len_left--;
				if (len_left == 0) begin
					dec_mode = MODE_TOKEN;
					add_event(EV_STR_END, 8'h00, 1'b0, ERR_TOKEN);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic predict_beat(input in_t beat);
		int   base;
		out_t tail;
		base = events_due.size();
		if (dec_mode != MODE_HALT) begin
			if (beat.end_of_input)
				unwind_stream();
			else
				decode_byte(beat.in_byte);
			if (events_due.size() > base) begin
				tail = events_due.pop_back();
				tail.last = 1'b1;
				events_due.push_back(tail);
			end
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic compare_beat(input out_t got);
		out_t want;
		if (events_due.size() == 0) begin
			report($sformatf("no result expected, got event %0d byte %02h",
				got.event_res, got.out_byte));
		end else begin
			want = events_due.pop_front();
			check_field("event_res", int'(got.event_res), int'(want.event_res));
			check_field("out_byte", int'(got.out_byte), int'(want.out_byte));
			check_field("printable", int'(got.printable), int'(want.printable));
			check_field("error_code", int'(got.error_code), int'(want.error_code));
			check_field("last", int'(got.last), int'(want.last));
		end
		beats_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_mode = MODE_TOKEN;
			depth = 0;
			len_left = 0;
			events_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (item_valid && !item_stall)
				predict_beat(item);
			if (res_valid && !res_stall)
				compare_beat(res);
			fail_count <= mismatches;
			pending <= events_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import bsd_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int LEN_BITS    = 32;
	localparam int ITEM_TARGET = 120;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 64;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t  item;
	logic res_valid;
	logic res_stall;
	out_t res;
	int   fail_count;
	int   pending;

	int open_count = 0;
	int sent = 0;
	int idle_cycles = 0;
	int calm_in = 0;
	int calm_out = 0;

	bencode_stream_decoder_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.LEN_BITS(LEN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	bencode_checker #(
		.STACK_DEPTH(STACK_DEPTH),
		.LEN_BITS(LEN_BITS)
	) watch (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random idle gaps, and occasional calm stretches with no idling at all
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 32);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic eoi);
		int gap;
		gap = draw_wait(calm_in);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{in_byte: b, end_of_input: eoi};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic open_box(input logic [7:0] kind);
		send_beat(kind, 1'b0);
		open_count++;
	endtask

	task automatic close_box();
		send_beat(CH_END, 1'b0);
		open_count--;
	endtask

	task automatic dive();
		while (open_count < STACK_DEPTH)
			open_box($urandom_range(0, 1) ? CH_DICT : CH_LIST);
	endtask

	function automatic logic [7:0] int_char();
		string numerals;
		logic [7:0] c;
		numerals = "-0123456789";
		if ($urandom_range(0, 3) != 0)
			return numerals[$urandom_range(0, 10)];
		do c = 8'($urandom_range(0, 255)); while (c == CH_END);
		return c;
	endfunction

	task automatic send_int();
		send_beat(CH_INT, 1'b0);
		repeat ($urandom_range(0, 6)) send_beat(int_char(), 1'b0);
		send_beat(CH_END, 1'b0);
	endtask

	task automatic send_str(input int unsigned n);
		string digits;
		digits = $sformatf("%0d", n);
		if ($urandom_range(0, 5) == 0)
			digits = {"0", digits};
		send_text(digits);
		send_beat(CH_COLON, 1'b0);
		repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// ends the stream in one of the halting ways, picked by the seed
	task automatic end_stream();
		logic [7:0] b;
		case ($urandom_range(0, 8))
			0: begin
				if ($urandom_range(0, 1)) begin
					send_beat(CH_INT, 1'b0);
					send_beat(int_char(), 1'b0);
				end
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			1: begin
				dive();
				send_beat(CH_INT, 1'b0);
				repeat ($urandom_range(0, 3)) send_beat(int_char(), 1'b0);
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			2: begin
				while (open_count > 0) close_box();
				send_beat(CH_END, 1'b0);
			end
			3: begin
				do b = 8'($urandom_range(0, 255));
				while (b == CH_DICT || b == CH_LIST || b == CH_INT || b == CH_END ||
					(b >= CH_ZERO && b <= CH_NINE));
				send_beat(b, 1'b0);
			end
			4: begin
				dive();
				send_beat($urandom_range(0, 1) ? CH_DICT : CH_LIST, 1'b0);
			end
			5: begin
				send_text("4294967295");
				send_beat(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
			end
			6: begin
				send_text($sformatf("%0d", $urandom_range(0, 999)));
				do b = 8'($urandom_range(0, 255));
				while (b == CH_COLON || (b >= CH_ZERO && b <= CH_NINE));
				send_beat(b, 1'b0);
			end
			7: begin
				if ($urandom_range(0, 1))
					send_text("4294967295");
				else
					send_text($sformatf("%0d", $urandom_range(0, 99)));
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				send_text("5:");
				repeat ($urandom_range(0, 4)) send_beat(8'($urandom_range(0, 255)), 1'b0);
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	initial begin
		int hold;
		res_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = draw_wait(calm_out);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		open_box(CH_LIST);
		open_box(CH_DICT);
		send_text("0:");
		send_beat(CH_INT, 1'b0);
		send_beat(8'h00, 1'b0);
		send_text("-7");
		send_beat(8'hff, 1'b0);
		send_beat(CH_END, 1'b0);
		send_text("6:");
		send_beat(8'h00, 1'b0);
		send_beat(8'h1f, 1'b0);
		send_beat(8'h20, 1'b0);
		send_beat(8'h7e, 1'b0);
		send_beat(8'h7f, 1'b0);
		send_beat(8'hff, 1'b0);
		send_text("01:A");
		close_box();
		close_box();

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3: begin
					if (open_count < STACK_DEPTH)
						open_box($urandom_range(0, 1) ? CH_DICT : CH_LIST);
					else
						close_box();
				end
				4, 5, 6: begin
					if (open_count > 0)
						close_box();
					else
						open_box($urandom_range(0, 1) ? CH_DICT : CH_LIST);
				end
				7, 8, 9: send_int();
				10, 11, 12, 13: begin
					if ($urandom_range(0, 7) == 0)
						send_str($urandom_range(7, 40));
					else
						send_str($urandom_range(0, 6));
				end
				14: dive();
				default: send_text("0:");
			endcase
		end

		end_stream();
		// halted now: these beats must be dropped
		for (int i = 0; i < 6; i++)
			send_beat(8'($urandom_range(0, 255)), i[0]);
		item_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bsd_pkg.sv
src/bsd_ctrl.sv
src/bsd_datapath.sv
src/bencode_stream_decoder_core.sv
src/bsd_checker.sv
tb/sv/bencode_checker.sv
tb/sv/testbench.sv
